// File: src/gsm_pkg.sv
// Shared types, constants and GF(2^8) helpers for the stripe multiplier.
// Used by every module in this block; depends on nothing else.
`timescale 1ns / 1ps

package gsm_pkg;

	// Store geometry and the rows and columns the datapath provides
	localparam int MaxRows = 16;
	localparam int MaxCols = 16;
	localparam int HwRows  = 16;
	localparam int HwCols  = 16;

	// Usable rows and columns: the smaller of store and datapath
	localparam int RowLim = (HwRows < MaxRows) ? HwRows : MaxRows;
	localparam int ColLim = (HwCols < MaxCols) ? HwCols : MaxCols;

	// Field widths fixed by the interface
	localparam int CntW  = 5;
	localparam int RowW  = 4;
	localparam int ColW  = 4;
	localparam int ByteW = 8;
	localparam int CfgIdxW = 2;

	// Index widths for the internal arrays
	localparam int RowIdxW = (RowLim > 1) ? $clog2(RowLim) : 1;
	localparam int ColIdxW = (ColLim > 1) ? $clog2(ColLim) : 1;

	localparam logic [CntW-1:0] RowLimC = CntW'(RowLim);
	localparam logic [CntW-1:0] ColLimC = CntW'(ColLim);

	// Queue between front and back
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Transaction kinds
	localparam logic KindCoeff = 1'b0;
	localparam logic KindData  = 1'b1;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegRows = 2'd0;
	localparam logic [CfgIdxW-1:0] RegCols = 2'd1;
	localparam logic [CfgIdxW-1:0] RegPoly = 2'd2;

	// Reset values of the configuration registers
	localparam logic [CntW-1:0]  RowsReset = 5'd16;
	localparam logic [CntW-1:0]  ColsReset = 5'd16;
	localparam logic [ByteW-1:0] PolyReset = 8'h1d;

	// Effective configuration as seen by the datapath
	typedef struct packed {
		logic [CntW-1:0]  n;
		logic [CntW-1:0]  k;
		logic [ByteW-1:0] poly;
	} cfg_t;

	// Classified transaction passed from front to back
	typedef struct packed {
		logic             is_coeff;
		logic [RowW-1:0]  row;
		logic [ColW-1:0]  col;
		logic [ByteW-1:0] value;
		logic             close;
		logic             eoc;
	} item_t;

	// Saturate a count to 1..lim
	function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] v,
			input logic [CntW-1:0] lim);
		logic [CntW-1:0] res;
		if (v == '0) begin
			res = CntW'(1);
		end else if (v > lim) begin
			res = lim;
		end else begin
			res = v;
		end
		return res;
	endfunction

	// Shift-and-add product in GF(2^8), x^8 implied in the polynomial
	function automatic logic [ByteW-1:0] gf_mul(input logic [ByteW-1:0] a,
			input logic [ByteW-1:0] b, input logic [ByteW-1:0] poly);
		logic [ByteW-1:0] x;
		logic [ByteW-1:0] acc;
		logic             carry;
		x   = a;
		acc = '0;
		for (int i = 0; i < ByteW; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			carry = x[ByteW-1];
			x     = {x[ByteW-2:0], 1'b0};
			if (carry) begin
				x = x ^ poly;
			end
		end
		return acc;
	endfunction

endpackage

// File: src/gsm_front.sv
// Front end: accepts input transactions, drops those without effect and
// marks the byte that closes a position. Depends on gsm_pkg.
`timescale 1ns / 1ps

module gsm_front
	import gsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic [RowW-1:0]  row_index,
	input  logic [ColW-1:0]  col_index,
	input  logic [ByteW-1:0] value,
	input  logic             end_of_chunk,
	output logic             push_valid,
	output item_t            push_item,
	input  logic             push_full
);

	logic  v_s1;
	item_t item_s1;
	logic  keep;
	logic  close;
	logic  in_take;

	// Classify: keep in-range coefficient writes and active-column data
	always_comb begin
		if (kind == KindData) begin
			keep = ({1'b0, col_index} < cfg.k);
		end else begin
			keep = (int'(row_index) < RowLim) && (int'(col_index) < ColLim);
		end
		close = ({1'b0, col_index} == (cfg.k - CntW'(1)));
	end

	// Hold while the queue is full
	assign in_stall = v_s1 && push_full;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.is_coeff <= (kind == KindCoeff);
			item_s1.row      <= row_index;
			item_s1.col      <= col_index;
			item_s1.value    <= value;
			item_s1.close    <= close;
			item_s1.eoc      <= end_of_chunk;
		end
	end

	assign push_valid = v_s1;
	assign push_item  = item_s1;

endmodule

// File: src/gsm_queue.sv
// Short queue of classified transactions between front and back.
// Depends on gsm_pkg.
`timescale 1ns / 1ps

module gsm_queue
	import gsm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_full,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	item_t            slot_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_full = (cnt_q == QCntW'(QDepth));
	assign q_valid   = (cnt_q != '0);
	assign q_item    = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = q_pop && q_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("queue occupancy above depth");
`endif

endmodule

// File: src/gsm_back.sv
// Back end: coefficient store, per-row GF multiply-accumulate and the
// result sequencer. Depends on gsm_pkg.
`timescale 1ns / 1ps

module gsm_back
	import gsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [RowW-1:0]  out_row,
	output logic [ByteW-1:0] out_byte,
	output logic             last_of_position,
	output logic             last_of_chunk
);

	// One coefficient memory per row, addressed by column
	logic [ByteW-1:0] coeff_mem [RowLim][ColLim];
	logic [ByteW-1:0] rd_s1     [RowLim];
	logic             v_s1;
	item_t            item_s1;

	logic [ByteW-1:0] acc_q    [RowLim];
	logic [ByteW-1:0] acc_nxt  [RowLim];
	logic [ByteW-1:0] snap_q   [RowLim];
	logic             snap_valid_q;
	logic [RowIdxW-1:0] emit_row_q;
	logic             snap_eoc_q;

	logic [CntW-1:0]    n_m1;
	logic [RowIdxW-1:0] last_row;
	logic               is_last;
	logic               out_take;
	logic               snap_free;
	logic               s1_consume;
	logic               accumulate;
	logic               close_now;

	assign n_m1     = cfg.n - CntW'(1);
	assign last_row = n_m1[RowIdxW-1:0];
	assign is_last  = (emit_row_q == last_row);
	assign out_take = snap_valid_q && !out_stall;

	// Snapshot buffer can take a new position once the old one drains
	assign snap_free  = !snap_valid_q || (out_take && is_last);
	assign s1_consume = v_s1 && (item_s1.is_coeff || !item_s1.close || snap_free);
	assign q_pop      = q_valid && (!v_s1 || s1_consume);
	assign accumulate = s1_consume && !item_s1.is_coeff;
	assign close_now  = accumulate && item_s1.close;

	// Write coefficients and read one column across all rows
	always_ff @(posedge clk) begin
		if (q_pop && q_item.is_coeff) begin
			coeff_mem[q_item.row[RowIdxW-1:0]][q_item.col[ColIdxW-1:0]] <= q_item.value;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int r = 0; r < RowLim; r++) begin
				rd_s1[r] <= coeff_mem[r][q_item.col[ColIdxW-1:0]];
			end
			item_s1 <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || s1_consume) begin
			v_s1 <= q_pop;
		end
	end

	// Multiply-accumulate on active rows only
	always_comb begin
		for (int r = 0; r < RowLim; r++) begin
			if (r < int'(cfg.n)) begin
				acc_nxt[r] = acc_q[r] ^ gf_mul(rd_s1[r], item_s1.value, cfg.poly);
			end else begin
				acc_nxt[r] = acc_q[r];
			end
		end
	end

	// Clear accumulators once a position closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < RowLim; r++) begin
				acc_q[r] <= '0;
			end
		end else if (accumulate) begin
			for (int r = 0; r < RowLim; r++) begin
				acc_q[r] <= item_s1.close ? '0 : acc_nxt[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close_now) begin
			snap_q     <= acc_nxt;
			snap_eoc_q <= item_s1.eoc;
		end
	end

	// Step through the rows of the captured position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
			emit_row_q   <= '0;
		end else if (close_now) begin
			snap_valid_q <= 1'b1;
			emit_row_q   <= '0;
		end else if (out_take) begin
			if (is_last) begin
				snap_valid_q <= 1'b0;
			end else begin
				emit_row_q <= emit_row_q + 1'b1;
			end
		end
	end

	assign out_valid        = snap_valid_q;
	assign out_row          = RowW'(emit_row_q);
	assign out_byte         = snap_q[emit_row_q];
	assign last_of_position = is_last;
	assign last_of_chunk    = is_last && snap_eoc_q;

`ifndef SYNTH
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid_q |-> (emit_row_q <= last_row))
		else $error("result row beyond active rows");
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		close_now |=> (acc_q[0] == '0))
		else $error("accumulator not cleared after position close");
	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(snap_valid_q && out_stall) |=> (snap_valid_q && $stable(emit_row_q)))
		else $error("result sequencer moved while output stalled");
`endif

endmodule

// File: src/gf256_matrix_stripe_multiply_top.sv
// Throughput: one input transaction per cycle unless in_stall holds it; a
// closing data byte yields n results, one per cycle unless out_stall holds
// them, from a snapshot buffer while the next position accumulates. The first
// result follows the front register, queue, store read and multiply-accumulate.
// Reset: asynchronous; clears control, accumulators and config to defaults.
// The coefficient store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module gf256_matrix_stripe_multiply_top
	import gsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [RowW-1:0]    row_index,
	input  logic [ColW-1:0]    col_index,
	input  logic [ByteW-1:0]   value,
	input  logic               end_of_chunk,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [RowW-1:0]    out_row,
	output logic [ByteW-1:0]   out_byte,
	output logic               last_of_position,
	output logic               last_of_chunk
);

	logic [CntW-1:0]  rows_q;
	logic [CntW-1:0]  cols_q;
	logic [ByteW-1:0] poly_q;
	cfg_t             cfg;

	logic  push_valid;
	item_t push_item;
	logic  push_full;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RowsReset;
			cols_q <= ColsReset;
			poly_q <= PolyReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegRows: rows_q <= cfg_data[CntW-1:0];
				RegCols: cols_q <= cfg_data[CntW-1:0];
				RegPoly: poly_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturated counts for the datapath
	assign cfg.n    = clamp_cnt(rows_q, RowLimC);
	assign cfg.k    = clamp_cnt(cols_q, ColLimC);
	assign cfg.poly = poly_q;

	gsm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.row_index    (row_index),
		.col_index    (col_index),
		.value        (value),
		.end_of_chunk (end_of_chunk),
		.push_valid   (push_valid),
		.push_item    (push_item),
		.push_full    (push_full)
	);

	gsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_full  (push_full),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	gsm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_row          (out_row),
		.out_byte         (out_byte),
		.last_of_position (last_of_position),
		.last_of_chunk    (last_of_chunk)
	);

endmodule
